>>> sv/fsa_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and field widths of the free list slot allocator.
package fsa_pkg;

    // Fixed widths of the item fields and the configuration port.
    localparam int OP_W       = 2;
    localparam int HIDX_W     = 8;
    localparam int HTAG_W     = 32;
    localparam int ADDR_W     = 32;
    localparam int STAT_W     = 2;
    localparam int SLOT_W     = 8;
    localparam int TAG_OUT_W  = 32;
    localparam int BASE_W     = 32;
    localparam int EB_W       = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;
    localparam logic [OP_W-1:0] OP_FIND    = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;
    localparam logic [STAT_W-1:0] STAT_OUTSIDE = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BYTES = 4'd1;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_ALLOC,
        ST_REL,
        ST_FIND_CHK,
        ST_FIND_DIV,
        ST_FIND_RD
    } t_state;

endpackage

>>> sv/free_list_slot_allocator_top.sv
`timescale 1ns / 1ps
// Top level of the free list slot allocator with generation tags.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+---------------------------------------------
//  in      | i_in_valid / o_in_ready   | i_operation, i_handle_index, i_handle_tag,
//          |                           | i_address
//  out     | o_out_valid / i_out_ready | o_status, o_slot, o_tag
//  cfg     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Allocate and release read the link or tag RAM, then write the result back.
// Find checks the address range, then runs the one-bit-per-cycle divider, then reads the tag RAM.
// Clear rewrites one RAM entry per cycle and ends only when the output register is free.
// After reset the same sweep runs with o_in_ready low.
// An item finishes only when the output register is free; a new item is taken
// while a finished result still waits in that register.
module free_list_slot_allocator_top #(
    parameter int POOL_ENTRIES = 256,
    parameter int TAG_BITS     = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [fsa_pkg::OP_W-1:0]           i_operation,
    input  logic [fsa_pkg::HIDX_W-1:0]         i_handle_index,
    input  logic [fsa_pkg::HTAG_W-1:0]         i_handle_tag,
    input  logic [fsa_pkg::ADDR_W-1:0]         i_address,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [fsa_pkg::STAT_W-1:0]         o_status,
    output logic [fsa_pkg::SLOT_W-1:0]         o_slot,
    output logic [fsa_pkg::TAG_OUT_W-1:0]      o_tag,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fsa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fsa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int IDX_W  = $clog2(POOL_ENTRIES);
    localparam int LINK_W = $clog2(POOL_ENTRIES + 1);
    localparam int DIV_W  = fsa_pkg::EB_W + IDX_W;
    localparam int CMP_W  = 33 + IDX_W;
    localparam int K_W    = $clog2(IDX_W + 1);
    localparam int OTW    = fsa_pkg::TAG_OUT_W;
    localparam int SW     = fsa_pkg::SLOT_W;
    localparam int AW     = fsa_pkg::ADDR_W;

    localparam logic [TAG_BITS-1:0] TAG_MASK = '1;
    localparam logic [LINK_W-1:0]   END_MARK = LINK_W'(POOL_ENTRIES);
    localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(POOL_ENTRIES - 1);

    fsa_pkg::t_state r_state, n_state;

    logic [LINK_W-1:0]            r_head, n_head;
    logic [TAG_BITS-1:0]          r_cnt, n_cnt;
    logic [IDX_W-1:0]             r_sw, n_sw;
    logic                         r_clr, n_clr;
    logic [fsa_pkg::HIDX_W-1:0]   r_hidx, n_hidx;
    logic [fsa_pkg::HTAG_W-1:0]   r_htag, n_htag;
    logic [AW-1:0]                r_addr, n_addr;
    logic [DIV_W-1:0]             r_rem, n_rem;
    logic [DIV_W-1:0]             r_dvs, n_dvs;
    logic [IDX_W-1:0]             r_q, n_q;
    logic [K_W-1:0]               r_k, n_k;
    logic [fsa_pkg::BASE_W-1:0]   r_base;
    logic [fsa_pkg::EB_W-1:0]     r_eb;
    logic [DIV_W-1:0]             r_span;
    logic                         r_out_valid;
    logic [fsa_pkg::STAT_W-1:0]   r_status, n_status;
    logic [SW-1:0]                r_slot, n_slot;
    logic [OTW-1:0]               r_tag, n_tag;
    logic                         load;

    logic                         in_acc;
    logic                         out_free;
    logic                         sweep_last;
    logic                         outside;
    logic [32:0]                  off_full;
    logic [fsa_pkg::EB_W-1:0]     eb_eff;
    logic                         div_ge;
    logic [IDX_W-1:0]             div_q;
    logic                         hidx_ok;
    logic                         live;
    logic [TAG_BITS-1:0]          cnt_inc;

    logic                         tag_we, tag_re;
    logic [IDX_W-1:0]             tag_waddr, tag_raddr;
    logic [TAG_BITS-1:0]          tag_wdata, tag_rdata;
    logic                         link_we, link_re;
    logic [IDX_W-1:0]             link_waddr, link_raddr;
    logic [LINK_W-1:0]            link_wdata, link_rdata;

    fsa_ram #(.WIDTH(TAG_BITS), .DEPTH(POOL_ENTRIES)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (tag_wdata),
        .i_re    (tag_re),
        .i_raddr (tag_raddr),
        .o_rdata (tag_rdata)
    );

    fsa_ram #(.WIDTH(LINK_W), .DEPTH(POOL_ENTRIES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    assign o_in_ready  = (r_state == fsa_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign sweep_last  = (r_sw == LAST_IDX);

    // Address range check: a borrow means the address lies below the base.
    assign eb_eff   = (r_eb == '0) ? fsa_pkg::EB_W'(1) : r_eb;
    assign off_full = {1'b0, r_addr} - {1'b0, r_base};
    assign outside  = off_full[32] || (CMP_W'(off_full[31:0]) >= CMP_W'(r_span));

    // One quotient bit per cycle, divisor pre-shifted and moved right each step.
    assign div_ge = (r_rem >= r_dvs);
    assign div_q  = IDX_W'({r_q, div_ge});

    assign hidx_ok = (32'(r_hidx) < 32'(POOL_ENTRIES));
    assign live    = hidx_ok && (tag_rdata != TAG_MASK) && (OTW'(tag_rdata) == r_htag);
    assign cnt_inc = r_cnt + TAG_BITS'(1);

    // Datapath and memory control.
    always_comb begin
        tag_we     = 1'b0;
        tag_waddr  = r_sw;
        tag_wdata  = TAG_MASK;
        tag_re     = 1'b0;
        tag_raddr  = IDX_W'(i_handle_index);
        link_we    = 1'b0;
        link_waddr = r_sw;
        link_wdata = LINK_W'(r_sw) + LINK_W'(1);
        link_re    = 1'b0;
        link_raddr = IDX_W'(r_head);
        load       = 1'b0;
        n_status   = fsa_pkg::STAT_OK;
        n_slot     = '0;
        n_tag      = '0;
        n_head     = r_head;
        n_cnt      = r_cnt;
        n_sw       = r_sw;
        n_clr      = r_clr;
        n_hidx     = r_hidx;
        n_htag     = r_htag;
        n_addr     = r_addr;
        n_rem      = r_rem;
        n_dvs      = r_dvs;
        n_q        = r_q;
        n_k        = r_k;
        unique case (r_state)
            fsa_pkg::ST_SWEEP: begin
                tag_we  = 1'b1;
                link_we = 1'b1;
                if (sweep_last) begin
                    if (!r_clr || out_free) begin
                        n_head = '0;
                        n_sw   = '0;
                        n_clr  = 1'b0;
                        load   = r_clr;
                    end
                end else begin
                    n_sw = r_sw + IDX_W'(1);
                end
            end
            fsa_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_hidx = i_handle_index;
                    n_htag = i_handle_tag;
                    n_addr = i_address;
                    unique case (i_operation)
                        fsa_pkg::OP_ALLOC:   link_re = 1'b1;
                        fsa_pkg::OP_RELEASE: tag_re  = 1'b1;
                        fsa_pkg::OP_CLEAR: begin
                            n_clr = 1'b1;
                            n_sw  = '0;
                        end
                        fsa_pkg::OP_FIND: ;
                    endcase
                end
            end
            fsa_pkg::ST_ALLOC: begin
                if (out_free) begin
                    load = 1'b1;
                    if (r_head == END_MARK) begin
                        n_status = fsa_pkg::STAT_FULL;
                        n_tag    = '1;
                    end else begin
                        tag_we    = 1'b1;
                        tag_waddr = IDX_W'(r_head);
                        tag_wdata = r_cnt;
                        n_head    = link_rdata;
                        // All ones marks an unused slot, so the counter skips it.
                        n_cnt     = (cnt_inc == TAG_MASK) ? '0 : cnt_inc;
                        n_slot    = SW'(r_head);
                        n_tag     = OTW'(r_cnt);
                    end
                end
            end
            fsa_pkg::ST_REL: begin
                if (out_free) begin
                    load   = 1'b1;
                    n_slot = r_hidx;
                    if (live) begin
                        tag_we     = 1'b1;
                        tag_waddr  = IDX_W'(r_hidx);
                        link_we    = 1'b1;
                        link_waddr = IDX_W'(r_hidx);
                        link_wdata = r_head;
                        n_head     = LINK_W'(r_hidx);
                    end else begin
                        n_status = fsa_pkg::STAT_INVALID;
                    end
                end
            end
            fsa_pkg::ST_FIND_CHK: begin
                if (outside) begin
                    if (out_free) begin
                        load     = 1'b1;
                        n_status = fsa_pkg::STAT_OUTSIDE;
                        n_tag    = '1;
                    end
                end else begin
                    n_rem = DIV_W'(off_full[31:0]);
                    n_dvs = DIV_W'(eb_eff) << (IDX_W - 1);
                    n_q   = '0;
                    n_k   = K_W'(IDX_W - 1);
                end
            end
            fsa_pkg::ST_FIND_DIV: begin
                n_rem = div_ge ? (r_rem - r_dvs) : r_rem;
                n_dvs = r_dvs >> 1;
                n_q   = div_q;
                n_k   = r_k - K_W'(1);
                if (r_k == '0) begin
                    tag_re    = 1'b1;
                    tag_raddr = div_q;
                end
            end
            fsa_pkg::ST_FIND_RD: begin
                if (out_free) begin
                    load   = 1'b1;
                    n_slot = SW'(r_q);
                    n_tag  = OTW'(tag_rdata);
                end
            end
            default: ;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fsa_pkg::ST_SWEEP: begin
                if (sweep_last && (!r_clr || out_free)) begin
                    n_state = fsa_pkg::ST_IDLE;
                end
            end
            fsa_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_operation)
                        fsa_pkg::OP_ALLOC:   n_state = fsa_pkg::ST_ALLOC;
                        fsa_pkg::OP_RELEASE: n_state = fsa_pkg::ST_REL;
                        fsa_pkg::OP_CLEAR:   n_state = fsa_pkg::ST_SWEEP;
                        fsa_pkg::OP_FIND:    n_state = fsa_pkg::ST_FIND_CHK;
                    endcase
                end
            end
            fsa_pkg::ST_ALLOC, fsa_pkg::ST_REL, fsa_pkg::ST_FIND_RD: begin
                if (out_free) begin
                    n_state = fsa_pkg::ST_IDLE;
                end
            end
            fsa_pkg::ST_FIND_CHK: begin
                if (!outside) begin
                    n_state = fsa_pkg::ST_FIND_DIV;
                end else if (out_free) begin
                    n_state = fsa_pkg::ST_IDLE;
                end
            end
            fsa_pkg::ST_FIND_DIV: begin
                if (r_k == '0) begin
                    n_state = fsa_pkg::ST_FIND_RD;
                end
            end
            default: n_state = fsa_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fsa_pkg::ST_SWEEP;
            r_head      <= '0;
            r_cnt       <= '0;
            r_sw        <= '0;
            r_clr       <= 1'b0;
            r_base      <= '0;
            r_eb        <= fsa_pkg::EB_W'(1);
            r_span      <= DIV_W'(POOL_ENTRIES);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_cnt   <= n_cnt;
            r_sw    <= n_sw;
            r_clr   <= n_clr;
            r_span  <= DIV_W'(eb_eff) * DIV_W'(POOL_ENTRIES);
            if (i_cfg_valid && o_cfg_ready) begin
                priority if (i_cfg_index == fsa_pkg::REG_BASE_ADDRESS) begin
                    r_base <= i_cfg_data;
                end else if (i_cfg_index == fsa_pkg::REG_ELEMENT_BYTES) begin
                    r_eb <= i_cfg_data[fsa_pkg::EB_W-1:0];
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hidx <= n_hidx;
        r_htag <= n_htag;
        r_addr <= n_addr;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_q    <= n_q;
        r_k    <= n_k;
        if (load) begin
            r_status <= n_status;
            r_slot   <= n_slot;
            r_tag    <= n_tag;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_slot      = r_slot;
    assign o_tag       = r_tag;

endmodule

>>> sv/fsa_ram.sv
`timescale 1ns / 1ps
// Generic single write port RAM with one registered read port.
module fsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // Read data holds while no read is issued.
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/fsa_checker.sv
`timescale 1ns / 1ps
// Port level checker of the free list slot allocator and its bind.
module fsa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [fsa_pkg::STAT_W-1:0]     o_status,
    input logic [fsa_pkg::SLOT_W-1:0]     o_slot,
    input logic [fsa_pkg::TAG_OUT_W-1:0]  o_tag
);

    // A result waiting for the consumer keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_status) && $stable(o_slot) && $stable(o_tag))
        else $error("result changed while stalled");

    // The store is swept after reset, so no item is taken right away.
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("item taken during reset sweep");

    // Ready drops after an item is taken, while the item is worked on.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready stayed high after an item was taken");

    a_miss_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == fsa_pkg::STAT_FULL || o_status == fsa_pkg::STAT_OUTSIDE)
            |-> o_slot == '0 && o_tag == '1)
        else $error("full or outside result with wrong slot or tag");

    a_invalid_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == fsa_pkg::STAT_INVALID |-> o_tag == '0)
        else $error("invalid release result with nonzero tag");

endmodule

bind free_list_slot_allocator_top fsa_checker u_fsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_slot      (o_slot),
    .o_tag       (o_tag)
);
